// File: src/olt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_pkg
// Shared widths, operation and status codes, and the command/status
// structs that join the list controller and its datapath.
// ----------------------------------------------------------------------------
package olt_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int FUNC_W    = 3;
  localparam int POS_W     = 5;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 3;
  localparam int IDX_W     = 4;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT     = 3'd4,
    OP_ERASE      = 3'd5,
    OP_FIND       = 3'd6
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // where an operation's working position comes from
  typedef enum logic [1:0] {
    POS_INPUT = 2'd0,
    POS_ZERO  = 2'd1,
    POS_COUNT = 2'd2,
    POS_LAST  = 2'd3
  } pos_sel_t;

  typedef struct packed {
    logic     accept;
    logic     start_up;
    logic     start_down;
    logic     start_scan;
    pos_sel_t pos_sel;
    logic     step_up;
    logic     step_down;
    logic     step_scan;
    logic     fin_insert;
    logic     fin_erase;
    logic     load_out;
    logic     hit;
    status_t  status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_gt_count;
    logic pos_ge_count;
    logic busy;
    logic pend;
    logic match;
  } dp_stat_t;

endpackage

// File: src/olt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_ctrl
// Sequencer for the list table: decodes each accepted operation, runs the
// shift or scan sweep in the datapath, and hands the result to the output.
// ----------------------------------------------------------------------------
module olt_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [olt_pkg::FUNC_W-1:0] func,
  output logic                       out_valid,
  input  logic                       out_stall,
  input  olt_pkg::dp_stat_t          stat,
  output olt_pkg::dp_cmd_t           cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DOWN,
    S_SCAN,
    S_REPORT
  } state_t;

  state_t           state, state_next;
  olt_pkg::status_t status_q, status_next;
  logic             hit_q, hit_next;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd         = '0;
    state_next  = state;
    status_next = status_q;
    hit_next    = hit_q;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept  = 1'b1;
          hit_next    = 1'b0;
          status_next = olt_pkg::ST_OK;
          state_next  = S_REPORT;
          case (olt_pkg::op_t'(func))
            olt_pkg::OP_PUSH_BACK: begin
              if (stat.full) begin
                status_next = olt_pkg::ST_FULL;
              end else begin
                cmd.start_up = 1'b1;
                cmd.pos_sel  = olt_pkg::POS_COUNT;
                state_next   = S_SHIFT_UP;
              end
            end
            olt_pkg::OP_PUSH_FRONT: begin
              if (stat.full) begin
                status_next = olt_pkg::ST_FULL;
              end else begin
                cmd.start_up = 1'b1;
                cmd.pos_sel  = olt_pkg::POS_ZERO;
                state_next   = S_SHIFT_UP;
              end
            end
            olt_pkg::OP_POP_BACK: begin
              if (stat.empty) begin
                status_next = olt_pkg::ST_EMPTY;
              end else begin
                cmd.start_down = 1'b1;
                cmd.pos_sel    = olt_pkg::POS_LAST;
                state_next     = S_SHIFT_DOWN;
              end
            end
            olt_pkg::OP_POP_FRONT: begin
              if (stat.empty) begin
                status_next = olt_pkg::ST_EMPTY;
              end else begin
                cmd.start_down = 1'b1;
                cmd.pos_sel    = olt_pkg::POS_ZERO;
                state_next     = S_SHIFT_DOWN;
              end
            end
            olt_pkg::OP_INSERT: begin
              // full takes precedence over a bad position
              if (stat.full) begin
                status_next = olt_pkg::ST_FULL;
              end else if (stat.pos_gt_count) begin
                status_next = olt_pkg::ST_BAD_POS;
              end else begin
                cmd.start_up = 1'b1;
                cmd.pos_sel  = olt_pkg::POS_INPUT;
                state_next   = S_SHIFT_UP;
              end
            end
            olt_pkg::OP_ERASE: begin
              if (stat.pos_ge_count) begin
                status_next = olt_pkg::ST_BAD_POS;
              end else begin
                cmd.start_down = 1'b1;
                cmd.pos_sel    = olt_pkg::POS_INPUT;
                state_next     = S_SHIFT_DOWN;
              end
            end
            olt_pkg::OP_FIND: begin
              cmd.start_scan = 1'b1;
              state_next     = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        // drain the last moved word before writing the new one
        if (!stat.busy && !stat.pend) begin
          cmd.fin_insert = 1'b1;
          state_next     = S_REPORT;
        end else begin
          cmd.step_up = 1'b1;
        end
      end
      S_SHIFT_DOWN: begin
        if (!stat.busy && !stat.pend) begin
          cmd.fin_erase = 1'b1;
          state_next    = S_REPORT;
        end else begin
          cmd.step_down = 1'b1;
        end
      end
      S_SCAN: begin
        // stop issuing reads on a hit so the read address holds the index
        if (stat.match) begin
          hit_next   = 1'b1;
          state_next = S_REPORT;
        end else if (!stat.busy && !stat.pend) begin
          status_next = olt_pkg::ST_NOT_FOUND;
          state_next  = S_REPORT;
        end else begin
          cmd.step_scan = 1'b1;
        end
      end
      S_REPORT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.hit    = hit_q;
    cmd.status = status_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      status_q  <= olt_pkg::ST_OK;
      hit_q     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      status_q  <= status_next;
      hit_q     <= hit_next;
      out_valid <= cmd.load_out || (out_valid && out_stall);
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("result word loaded over a stalled one");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state != S_IDLE))
    else $error("accepted word did not start an operation");

endmodule

// File: src/olt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_dp
// List datapath: entry memory, count, sweep pointer and counter for shifts
// and scans, key compare, and the output word register.
// ----------------------------------------------------------------------------
module olt_dp #(
  parameter int CAPACITY = olt_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [olt_pkg::POS_W-1:0]     position,
  input  logic signed [olt_pkg::VAL_W-1:0] item_value,
  input  olt_pkg::dp_cmd_t              cmd,
  output olt_pkg::dp_stat_t             stat,
  output logic [olt_pkg::STAT_W-1:0]    status,
  output logic [olt_pkg::IDX_W-1:0]     found_index,
  output logic [olt_pkg::CNT_OUT_W-1:0] entry_count
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = CNT_W + olt_pkg::POS_W;

  logic [olt_pkg::VAL_W-1:0] mem [CAPACITY];

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          nr;
  logic                      pend;
  logic [AW-1:0]             ptr;
  logic [AW-1:0]             pos_q;
  logic [AW-1:0]             raddr_q;
  logic [olt_pkg::VAL_W-1:0] rdata;
  logic [olt_pkg::VAL_W-1:0] key;

  logic [CNT_W-1:0]          pos_in;
  logic [CNT_W-1:0]          eff;
  logic                      step;
  logic                      rd_en;

  assign pos_in = CNT_W'(position);

  always_comb begin
    case (cmd.pos_sel)
      olt_pkg::POS_INPUT: eff = pos_in;
      olt_pkg::POS_ZERO:  eff = '0;
      olt_pkg::POS_COUNT: eff = count;
      olt_pkg::POS_LAST:  eff = count - 1'b1;
      default:            eff = pos_in;
    endcase
  end

  assign step  = cmd.step_up || cmd.step_down || cmd.step_scan;
  assign rd_en = step && (nr != '0);

  assign stat.full         = (count == CNT_W'(CAPACITY));
  assign stat.empty        = (count == '0);
  assign stat.pos_gt_count = (CMP_W'(position) > CMP_W'(count));
  assign stat.pos_ge_count = (CMP_W'(position) >= CMP_W'(count));
  assign stat.busy         = (nr != '0);
  assign stat.pend         = pend;
  assign stat.match        = pend && (rdata == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      nr    <= '0;
      pend  <= 1'b0;
    end else begin
      if (cmd.start_up) begin
        nr <= count - eff;
      end else if (cmd.start_down) begin
        nr <= count - eff - 1'b1;
      end else if (cmd.start_scan) begin
        nr <= count;
      end else if (rd_en) begin
        nr <= nr - 1'b1;
      end

      if (cmd.start_up || cmd.start_down || cmd.start_scan) begin
        pend <= 1'b0;
      end else if (step) begin
        pend <= rd_en;
      end

      if (cmd.fin_insert) begin
        count <= count + 1'b1;
      end else if (cmd.fin_erase) begin
        count <= count - 1'b1;
      end
    end
  end

  // sweep pointer and operand words
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key <= item_value;
    end
    if (cmd.start_up) begin
      ptr   <= AW'(count - 1'b1);
      pos_q <= AW'(eff);
    end else if (cmd.start_down) begin
      ptr   <= AW'(eff + 1'b1);
      pos_q <= AW'(eff);
    end else if (cmd.start_scan) begin
      ptr <= '0;
    end else if (rd_en) begin
      ptr <= cmd.step_up ? ptr - 1'b1 : ptr + 1'b1;
    end
  end

  // entry memory: one read and one write port, read data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata   <= mem[ptr];
      raddr_q <= ptr;
    end
    if (cmd.step_up && pend) begin
      mem[raddr_q + 1'b1] <= rdata;
    end else if (cmd.step_down && pend) begin
      mem[raddr_q - 1'b1] <= rdata;
    end else if (cmd.fin_insert) begin
      mem[pos_q] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status      <= cmd.status;
      found_index <= cmd.hit ? olt_pkg::IDX_W'(raddr_q) : '0;
      entry_count <= olt_pkg::CNT_OUT_W'(count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_insert |-> !stat.full)
    else $error("insert into a full list");

  a_read_in_list: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (CNT_W'(ptr) < count))
    else $error("sweep read outside the held entries");

endmodule

// File: src/ordered_list_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_table
// Ordered list of signed 32-bit values in a store of CAPACITY entries.
// Each input word carries one operation (func), a position and a value;
// each operation returns exactly one result word: status, found_index and
// the entry_count after the operation. Both channels use valid/stall; a word
// moves on an edge with valid high and stall low.
// One operation runs at a time. A rejected operation or unused code goes
// straight to the result; push back, pop back and other move-free cases
// move no words; insert, erase, push front and pop front shift the words
// at or after the position; find reads from index 0 until a hit or the
// end of the list. The next word is taken in the cycle out_valid rises.
// Entries live in a single-port-write memory, so shifts and scans move one
// word per cycle; that sets the cost of the position-dependent operations.
// The next word is accepted as soon as the sequencer is idle, even while a
// result waits on a stalled output; its own result then waits in turn.
// Reset empties the list (count zero); the memory is not cleared.
// ----------------------------------------------------------------------------
module ordered_list_table #(
  parameter int CAPACITY = olt_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [olt_pkg::FUNC_W-1:0]       func,
  input  logic [olt_pkg::POS_W-1:0]        position,
  input  logic signed [olt_pkg::VAL_W-1:0] item_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [olt_pkg::STAT_W-1:0]       status,
  output logic [olt_pkg::IDX_W-1:0]        found_index,
  output logic [olt_pkg::CNT_OUT_W-1:0]    entry_count
);

  olt_pkg::dp_cmd_t  cmd;
  olt_pkg::dp_stat_t stat;

  olt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  olt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .position    (position),
    .item_value  (item_value),
    .cmd         (cmd),
    .stat        (stat),
    .status      (status),
    .found_index (found_index),
    .entry_count (entry_count)
  );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks ordered_list_table against a cycle-free list predictor. A short
// table of directed operations covers the empty, full and bad-position
// corners and the unused code, then about 450 random operations run in
// grow, shrink and mixed phases with random gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CAP        = olt_pkg::CAPACITY_DEF;
  localparam int N_RANDOM   = 450;
  localparam int PHASE_LEN  = 50;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_WAIT  = 40;
  localparam logic [olt_pkg::FUNC_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    olt_pkg::status_t                st;
    logic [olt_pkg::IDX_W-1:0]       idx;
    logic [olt_pkg::CNT_OUT_W-1:0]   cnt;
  } list_result_t;

  typedef struct {
    logic [olt_pkg::FUNC_W-1:0]      f;
    logic [olt_pkg::POS_W-1:0]       p;
    logic [olt_pkg::VAL_W-1:0]       v;
    int                              reps;
    bit                              typed;
    olt_pkg::status_t                st;
    logic [olt_pkg::IDX_W-1:0]       idx;
    logic [olt_pkg::CNT_OUT_W-1:0]   cnt;
  } stim_row_t;

  localparam int N_DIR = 28;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [olt_pkg::FUNC_W-1:0]          func = '0;
  logic [olt_pkg::POS_W-1:0]           position = '0;
  logic signed [olt_pkg::VAL_W-1:0]    item_value = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [olt_pkg::STAT_W-1:0]          status;
  logic [olt_pkg::IDX_W-1:0]           found_index;
  logic [olt_pkg::CNT_OUT_W-1:0]       entry_count;

  // predictor state
  logic [olt_pkg::VAL_W-1:0]           list_mem [CAP];
  int                                  list_len = 0;
  list_result_t                        pending_results [$];

  stim_row_t                           dir_rows [N_DIR];
  bit                                  no_idle = 1'b0;
  int                                  err_count = 0;
  int                                  words_sent = 0;
  int                                  results_seen = 0;
  int                                  stat_tally [8];
  int                                  idle_cycles = 0;
  int                                  stall_hold = 0;

  ordered_list_table u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .position    (position),
    .item_value  (item_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_index (found_index),
    .entry_count (entry_count)
  );

  always #6 clk = ~clk;

  function automatic void open_gap(int at, logic [olt_pkg::VAL_W-1:0] v);
    for (int i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
    list_mem[at] = v;
    list_len++;
  endfunction

  function automatic void close_gap(int at);
    for (int i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
    list_len--;
  endfunction

  function automatic list_result_t apply_list_op(logic [olt_pkg::FUNC_W-1:0] f,
                                                 logic [olt_pkg::POS_W-1:0]  p,
                                                 logic [olt_pkg::VAL_W-1:0]  v);
    list_result_t r;
    r.st  = olt_pkg::ST_OK;
    r.idx = '0;
    case (f)
      olt_pkg::OP_PUSH_BACK: begin
        if (list_len >= CAP) r.st = olt_pkg::ST_FULL;
        else open_gap(list_len, v);
      end
      olt_pkg::OP_PUSH_FRONT: begin
        if (list_len >= CAP) r.st = olt_pkg::ST_FULL;
        else open_gap(0, v);
      end
      olt_pkg::OP_POP_BACK: begin
        if (list_len == 0) r.st = olt_pkg::ST_EMPTY;
        else list_len--;
      end
      olt_pkg::OP_POP_FRONT: begin
        if (list_len == 0) r.st = olt_pkg::ST_EMPTY;
        else close_gap(0);
      end
      olt_pkg::OP_INSERT: begin
        if (list_len >= CAP) r.st = olt_pkg::ST_FULL;
        else if (int'(p) > list_len) r.st = olt_pkg::ST_BAD_POS;
        else open_gap(int'(p), v);
      end
      olt_pkg::OP_ERASE: begin
        if (int'(p) >= list_len) r.st = olt_pkg::ST_BAD_POS;
        else close_gap(int'(p));
      end
      olt_pkg::OP_FIND: begin
        r.st = olt_pkg::ST_NOT_FOUND;
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] == v) begin
            r.st  = olt_pkg::ST_OK;
            r.idx = i[olt_pkg::IDX_W-1:0];
            break;
          end
        end
      end
      default: ;
    endcase
    r.cnt = list_len[olt_pkg::CNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [olt_pkg::VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return olt_pkg::VAL_W'($urandom_range(0, 7));
    if (r < 55) return 32'h8000_0000;
    if (r < 60) return 32'h7fff_ffff;
    if (r < 65) return 32'hffff_ffff;
    return $urandom;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at result %0d, %s: got %0d, want %0d", results_seen, what, got, want);
    err_count++;
  endtask

  // hold the word until it is taken; never drop valid between back-to-back words
  task automatic send_word(logic [olt_pkg::FUNC_W-1:0] f, logic [olt_pkg::POS_W-1:0] p,
                           logic [olt_pkg::VAL_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    func       <= f;
    position   <= p;
    item_value <= v;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // receiver stalls: mostly short bursts, now and then a long one
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (no_idle) begin
      out_stall  <= 1'b0;
      stall_hold <= 4;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 5);
      end else if (r < 95) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      list_result_t want;
      results_seen++;
      stat_tally[status]++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", status, 0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) report_mismatch("status", status, want.st);
        if (found_index !== want.idx) report_mismatch("found_index", found_index, want.idx);
        if (entry_count !== want.cnt) report_mismatch("entry_count", entry_count, want.cnt);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    list_result_t                pred;
    int                          phase;
    int                          r;
    int                          grow_w;
    int                          shrink_w;
    logic [olt_pkg::FUNC_W-1:0]  f;
    logic [olt_pkg::POS_W-1:0]   p;
    logic [olt_pkg::VAL_W-1:0]   v;

    for (int i = 0; i < 8; i++) stat_tally[i] = 0;
    dir_rows = '{
      '{olt_pkg::OP_POP_BACK,   5'd0,  32'h0,         1,  1'b1,
        olt_pkg::ST_EMPTY,     4'd0, 5'd0},
      '{olt_pkg::OP_POP_FRONT,  5'd0,  32'h0,         1,  1'b1,
        olt_pkg::ST_EMPTY,     4'd0, 5'd0},
      '{olt_pkg::OP_ERASE,      5'd0,  32'h0,         1,  1'b1,
        olt_pkg::ST_BAD_POS,   4'd0, 5'd0},
      '{olt_pkg::OP_FIND,       5'd0,  32'h0,         1,  1'b1,
        olt_pkg::ST_NOT_FOUND, 4'd0, 5'd0},
      '{olt_pkg::OP_INSERT,     5'd1,  32'h5,         1,  1'b1,
        olt_pkg::ST_BAD_POS,   4'd0, 5'd0},
      '{OP_UNUSED,              5'd31, 32'hffff_ffff, 1,  1'b1,
        olt_pkg::ST_OK,        4'd0, 5'd0},
      '{olt_pkg::OP_PUSH_BACK,  5'd0,  32'h7fff_ffff, 1,  1'b1,
        olt_pkg::ST_OK,        4'd0, 5'd1},
      '{olt_pkg::OP_PUSH_FRONT, 5'd31, 32'h8000_0000, 1,  1'b1,
        olt_pkg::ST_OK,        4'd0, 5'd2},
      '{olt_pkg::OP_INSERT,     5'd2,  32'h0,         1,  1'b1,
        olt_pkg::ST_OK,        4'd0, 5'd3},
      '{olt_pkg::OP_INSERT,     5'd31, 32'hffff_ffff, 1,  1'b1,
        olt_pkg::ST_BAD_POS,   4'd0, 5'd3},
      '{olt_pkg::OP_FIND,       5'd0,  32'h8000_0000, 1,  1'b1,
        olt_pkg::ST_OK,        4'd0, 5'd3},
      '{olt_pkg::OP_FIND,       5'd0,  32'h0,         1,  1'b1,
        olt_pkg::ST_OK,        4'd2, 5'd3},
      '{olt_pkg::OP_FIND,       5'd0,  32'h5,         1,  1'b1,
        olt_pkg::ST_NOT_FOUND, 4'd0, 5'd3},
      '{olt_pkg::OP_ERASE,      5'd3,  32'h0,         1,  1'b1,
        olt_pkg::ST_BAD_POS,   4'd0, 5'd3},
      '{olt_pkg::OP_ERASE,      5'd1,  32'h0,         1,  1'b1,
        olt_pkg::ST_OK,        4'd0, 5'd2},
      '{olt_pkg::OP_INSERT,     5'd0,  32'hffff_ffff, 1,  1'b1,
        olt_pkg::ST_OK,        4'd0, 5'd3},
      '{olt_pkg::OP_PUSH_BACK,  5'd0,  32'd100,       13, 1'b0,
        olt_pkg::ST_OK,        4'd0, 5'd0},
      '{olt_pkg::OP_PUSH_BACK,  5'd0,  32'h1,         1,  1'b1,
        olt_pkg::ST_FULL,      4'd0, 5'd16},
      '{olt_pkg::OP_PUSH_FRONT, 5'd0,  32'h1,         1,  1'b1,
        olt_pkg::ST_FULL,      4'd0, 5'd16},
      '{olt_pkg::OP_INSERT,     5'd31, 32'h1,         1,  1'b1,
        olt_pkg::ST_FULL,      4'd0, 5'd16},
      '{olt_pkg::OP_FIND,       5'd0,  32'd112,       1,  1'b0,
        olt_pkg::ST_OK,        4'd0, 5'd0},
      '{olt_pkg::OP_ERASE,      5'd16, 32'h0,         1,  1'b1,
        olt_pkg::ST_BAD_POS,   4'd0, 5'd16},
      '{olt_pkg::OP_ERASE,      5'd15, 32'h0,         1,  1'b1,
        olt_pkg::ST_OK,        4'd0, 5'd15},
      '{olt_pkg::OP_POP_FRONT,  5'd0,  32'h0,         1,  1'b0,
        olt_pkg::ST_OK,        4'd0, 5'd0},
      '{OP_UNUSED,              5'd0,  32'h0,         1,  1'b1,
        olt_pkg::ST_OK,        4'd0, 5'd14},
      '{olt_pkg::OP_POP_BACK,   5'd0,  32'h0,         14, 1'b0,
        olt_pkg::ST_OK,        4'd0, 5'd0},
      '{olt_pkg::OP_POP_BACK,   5'd0,  32'h0,         1,  1'b1,
        olt_pkg::ST_EMPTY,     4'd0, 5'd0},
      '{olt_pkg::OP_PUSH_FRONT, 5'd0,  32'h0,         1,  1'b1,
        olt_pkg::ST_OK,        4'd0, 5'd1}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      for (int j = 0; j < dir_rows[k].reps; j++) begin
        v = dir_rows[k].v + olt_pkg::VAL_W'(j);
        send_word(dir_rows[k].f, dir_rows[k].p, v);
        pred = apply_list_op(dir_rows[k].f, dir_rows[k].p, v);
        if (dir_rows[k].typed) pending_results.push_back('{dir_rows[k].st, dir_rows[k].idx,
                                                             dir_rows[k].cnt});
        else pending_results.push_back(pred);
      end
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % PHASE_LEN == 0) begin
        phase   = $urandom_range(0, 2);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      case (phase)
        0:       begin grow_w = 65; shrink_w = 15; end
        1:       begin grow_w = 20; shrink_w = 60; end
        default: begin grow_w = 40; shrink_w = 35; end
      endcase
      r = $urandom_range(0, 99);
      v = pick_value();
      p = olt_pkg::POS_W'($urandom_range(0, 31));
      if (r < 3) begin
        f = OP_UNUSED;
      end else if (r < 3 + grow_w) begin
        case ($urandom_range(0, 2))
          0:       f = olt_pkg::OP_PUSH_BACK;
          1:       f = olt_pkg::OP_PUSH_FRONT;
          default: f = olt_pkg::OP_INSERT;
        endcase
        if (f == olt_pkg::OP_INSERT && $urandom_range(0, 99) < 85)
          p = olt_pkg::POS_W'($urandom_range(0, list_len));
      end else if (r < 3 + grow_w + shrink_w) begin
        case ($urandom_range(0, 2))
          0:       f = olt_pkg::OP_POP_BACK;
          1:       f = olt_pkg::OP_POP_FRONT;
          default: f = olt_pkg::OP_ERASE;
        endcase
        if (f == olt_pkg::OP_ERASE && list_len > 0 && $urandom_range(0, 99) < 85)
          p = olt_pkg::POS_W'($urandom_range(0, list_len - 1));
      end else begin
        f = olt_pkg::OP_FIND;
        // mostly look for something that is held, so hits land at every index
        if (list_len > 0 && $urandom_range(0, 99) < 70)
          v = list_mem[$urandom_range(0, list_len - 1)];
      end
      send_word(f, p, v);
      pending_results.push_back(apply_list_op(f, p, v));
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("ran %0d operations, %0d results checked", words_sent, results_seen);
    $display("statuses: ok %0d, full %0d, empty %0d, bad position %0d, not found %0d",
             stat_tally[olt_pkg::ST_OK], stat_tally[olt_pkg::ST_FULL],
             stat_tally[olt_pkg::ST_EMPTY], stat_tally[olt_pkg::ST_BAD_POS],
             stat_tally[olt_pkg::ST_NOT_FOUND]);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
